// ===== rtl/ffa_pkg.sv =====
// Shared types, constants and codes for the first-fit block allocator.
// Used by ffa_cell, ffa_ctrl, the top level and the checker. No dependencies.
`default_nettype none

package ffa_pkg;

   localparam int ARENA_BYTES  = 1024;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 32;

   localparam int OFS_W   = 10;
   localparam int SIZE_W  = 10;
   localparam int TOTAL_W = 11;

   localparam logic [SIZE_W-1:0]  HDR_SIZE    = SIZE_W'(HEADER_BYTES);
   localparam logic [OFS_W-1:0]   HDR_OFS     = OFS_W'(HEADER_BYTES);
   localparam logic [TOTAL_W-1:0] HDR_TOTAL   = TOTAL_W'(HEADER_BYTES);
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(ARENA_BYTES);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NOFIT  = 2'd1,
      STAT_BADOFS = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_SCAN  = 3'd2,
      CMD_OPEN  = 3'd3,
      CMD_TAKE  = 3'd4,
      CMD_MARK  = 3'd5,
      CMD_MNEXT = 3'd6,
      CMD_MPREV = 3'd7
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic              free;
      logic [OFS_W-1:0]  start;
      logic [SIZE_W-1:0] size;
   } block_type;

   typedef struct packed {
      logic      tok;
      block_type blk;
   } link_type;

   typedef struct packed {
      block_type cur;
      block_type prv;
      block_type nxt;
   } view_type;

   typedef struct packed {
      cmd_type           cmd;
      logic              action;
      logic [SIZE_W-1:0] req_size;
      logic              target_ok;
      logic [OFS_W-1:0]  target;
      logic [OFS_W-1:0]  split_start;
      logic [SIZE_W-1:0] split_size;
      logic [SIZE_W-1:0] merge_size;
   } bcast_type;

   typedef struct packed {
      logic     hit_any;
      logic     tok_last;
      logic     tail_valid;
      view_type view;
   } scan_type;

   localparam block_type BLOCK_EMPTY = '0;
   localparam block_type BLOCK_ARENA = '{
      valid: 1'b1,
      free:  1'b1,
      start: '0,
      size:  SIZE_W'(ARENA_BYTES - HEADER_BYTES)
   };

endpackage

`default_nettype wire

// ===== rtl/ffa_cell.sv =====
// One table cell: holds one block entry and a scan token, shifts with neighbors.
// Depends on ffa_pkg.
`default_nettype none

module ffa_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              head,
   input  ffa_pkg::block_type rst_blk,
   input  ffa_pkg::bcast_type bcast,
   input  ffa_pkg::link_type  prev_link,
   input  ffa_pkg::link_type  next_link,
   output ffa_pkg::link_type  link,
   output logic              hit,
   output ffa_pkg::view_type  view
);
   import ffa_pkg::*;

   block_type blk_ff, blk_in;
   logic      tok_ff, tok_in;
   logic      before_ff, before_in;
   logic      match;
   logic      after;

   always_comb begin
      if (bcast.action == ACT_ALLOC) begin
         match = blk_ff.valid & blk_ff.free & (blk_ff.size > bcast.req_size);
      end else begin
         match = blk_ff.valid & ~blk_ff.free & bcast.target_ok &
                 (blk_ff.start == bcast.target);
      end
   end

   assign after = ~before_ff & ~tok_ff;

   always_comb begin
      blk_in    = blk_ff;
      tok_in    = tok_ff;
      before_in = before_ff;
      unique case (bcast.cmd)
         CMD_NONE: begin
         end
         CMD_START: begin
            tok_in    = head;
            before_in = 1'b0;
         end
         CMD_SCAN: begin
            tok_in    = prev_link.tok;
            before_in = before_ff | tok_ff;
         end
         CMD_OPEN: begin
            priority if (tok_ff) begin
               blk_in.size = bcast.req_size;
               blk_in.free = 1'b0;
            end else if (prev_link.tok) begin
               blk_in = '{valid: 1'b1, free: 1'b1,
                          start: bcast.split_start, size: bcast.split_size};
            end else if (after) begin
               blk_in = prev_link.blk;
            end
         end
         CMD_TAKE: begin
            if (tok_ff) begin
               blk_in.free = 1'b0;
            end
         end
         CMD_MARK: begin
            if (tok_ff) begin
               blk_in.free = 1'b1;
            end
         end
         CMD_MNEXT: begin
            priority if (tok_ff) begin
               blk_in.free = 1'b1;
               blk_in.size = bcast.merge_size;
            end else if (after) begin
               blk_in = next_link.blk;
            end
         end
         CMD_MPREV: begin
            priority if (next_link.tok) begin
               blk_in.size = bcast.merge_size;
            end else if (tok_ff | after) begin
               blk_in = next_link.blk;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff    <= rst_blk;
         tok_ff    <= 1'b0;
         before_ff <= 1'b0;
      end else begin
         blk_ff    <= blk_in;
         tok_ff    <= tok_in;
         before_ff <= before_in;
      end
   end

   assign link = '{tok: tok_ff, blk: blk_ff};
   assign hit  = tok_ff & match;
   assign view = tok_ff ? view_type'{cur: blk_ff, prv: prev_link.blk, nxt: next_link.blk}
                        : view_type'('0);

endmodule

`default_nettype wire

// ===== rtl/ffa_ctrl.sv =====
// Sequencer: takes a request, walks the scan token, issues table updates, holds the result.
// Depends on ffa_pkg.
`default_nettype none

module ffa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic [ffa_pkg::SIZE_W-1:0]  req_size,
   input  logic [ffa_pkg::OFS_W-1:0]   req_data_offset,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [ffa_pkg::OFS_W-1:0]   rsp_granted_offset,
   output logic [ffa_pkg::SIZE_W-1:0]  rsp_granted_size,
   output logic [ffa_pkg::TOTAL_W-1:0] rsp_free_bytes,
   input  ffa_pkg::scan_type           scan,
   output ffa_pkg::bcast_type          bcast
);
   import ffa_pkg::*;

   typedef enum logic [4:0] {
      FSM_IDLE  = 5'b00001,
      FSM_SCAN  = 5'b00010,
      FSM_HIT   = 5'b00100,
      FSM_MPREV = 5'b01000,
      FSM_RESP  = 5'b10000
   } fsm_type;

   fsm_type             state_ff, state_in;
   logic                action_ff, action_in;
   logic [SIZE_W-1:0]   req_ff, req_in;
   logic [OFS_W-1:0]    target_ff, target_in;
   logic                target_ok_ff, target_ok_in;
   status_type          status_ff, status_in;
   logic [OFS_W-1:0]    gofs_ff, gofs_in;
   logic [SIZE_W-1:0]   gsize_ff, gsize_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [OFS_W-1:0]    rsp_gofs_ff, rsp_gofs_in;
   logic [SIZE_W-1:0]   rsp_gsize_ff, rsp_gsize_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;

   block_type           cur, prv, nxt;
   logic [TOTAL_W-1:0]  need;
   logic                split;
   logic [SIZE_W-1:0]   taken_size;
   logic [TOTAL_W-1:0]  taken_total;
   logic [TOTAL_W-1:0]  freed_total;
   cmd_type             cmd;

   assign cur = scan.view.cur;
   assign prv = scan.view.prv;
   assign nxt = scan.view.nxt;

   assign need        = TOTAL_W'(req_ff) + HDR_TOTAL;
   assign split       = TOTAL_W'(cur.size) > need;
   assign taken_size  = split ? req_ff : cur.size;
   assign taken_total = total_ff - TOTAL_W'(taken_size) - HDR_TOTAL;
   assign freed_total = total_ff + TOTAL_W'(cur.size) + HDR_TOTAL;

   always_comb begin
      bcast.cmd         = cmd;
      bcast.action      = action_ff;
      bcast.req_size    = req_ff;
      bcast.target_ok   = target_ok_ff;
      bcast.target      = target_ff;
      bcast.split_start = cur.start + need[OFS_W-1:0];
      bcast.split_size  = cur.size - need[SIZE_W-1:0];
      bcast.merge_size  = ((state_ff == FSM_MPREV) ? prv.size : nxt.size) + cur.size + HDR_SIZE;
   end

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      req_in        = req_ff;
      target_in     = target_ff;
      target_ok_in  = target_ok_ff;
      status_in     = status_ff;
      gofs_in       = gofs_ff;
      gsize_in      = gsize_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_gofs_in   = rsp_gofs_ff;
      rsp_gsize_in  = rsp_gsize_ff;
      rsp_total_in  = rsp_total_ff;
      cmd           = CMD_NONE;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               action_in    = req_action;
               req_in       = req_size;
               target_in    = req_data_offset - HDR_OFS;
               target_ok_in = req_data_offset >= HDR_OFS;
               cmd          = CMD_START;
               state_in     = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            priority if (scan.hit_any) begin
               state_in = FSM_HIT;
            end else if (~cur.valid | scan.tok_last) begin
               status_in = (action_ff == ACT_FREE) ? STAT_BADOFS : STAT_NOFIT;
               gofs_in   = '0;
               gsize_in  = '0;
               state_in  = FSM_RESP;
            end else begin
               cmd = CMD_SCAN;
            end
         end
         FSM_HIT: begin
            if (action_ff == ACT_ALLOC) begin
               if (split & scan.tail_valid) begin
                  status_in = STAT_FULL;
                  gofs_in   = '0;
                  gsize_in  = '0;
               end else begin
                  cmd       = split ? CMD_OPEN : CMD_TAKE;
                  status_in = STAT_OK;
                  gofs_in   = cur.start + HDR_OFS;
                  gsize_in  = taken_size;
                  total_in  = taken_total;
               end
               state_in = FSM_RESP;
            end else begin
               cmd       = (nxt.valid & nxt.free) ? CMD_MNEXT : CMD_MARK;
               status_in = STAT_OK;
               gofs_in   = '0;
               gsize_in  = cur.size;
               total_in  = freed_total;
               state_in  = FSM_MPREV;
            end
         end
         FSM_MPREV: begin
            if (prv.valid & prv.free) begin
               cmd = CMD_MPREV;
            end
            state_in = FSM_RESP;
         end
         FSM_RESP: begin
            if (~rsp_valid_ff | rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_gofs_in   = gofs_ff;
               rsp_gsize_in  = gsize_ff;
               rsp_total_in  = total_ff;
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         total_ff     <= TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      req_ff        <= req_in;
      target_ff     <= target_in;
      target_ok_ff  <= target_ok_in;
      status_ff     <= status_in;
      gofs_ff       <= gofs_in;
      gsize_ff      <= gsize_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gofs_ff   <= rsp_gofs_in;
      rsp_gsize_ff  <= rsp_gsize_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_ready          = (state_ff == FSM_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_gofs_ff;
   assign rsp_granted_size   = rsp_gsize_ff;
   assign rsp_free_bytes     = rsp_total_ff;

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: a row of ffa_cell entries and ffa_ctrl.
// Depends on ffa_pkg, ffa_cell, ffa_ctrl.
//
//   channel | ports                                          | direction
//   req     | req_valid/ready, action, size, data_offset     | in
//   rsp     | rsp_valid/ready, status, granted_offset/size,  | out
//           | free_bytes                                     |
//
// From accept to result, a request goes through a start step, a scan step for
// each table entry that the scan token passes along the cell row, then update
// steps and a result step.
// Reset loads one free block spanning the arena; no clearing pass.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its result waits until the previous one is taken.
`default_nettype none

module first_fit_block_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic [ffa_pkg::SIZE_W-1:0]  req_size,
   input  logic [ffa_pkg::OFS_W-1:0]   req_data_offset,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [ffa_pkg::OFS_W-1:0]   rsp_granted_offset,
   output logic [ffa_pkg::SIZE_W-1:0]  rsp_granted_size,
   output logic [ffa_pkg::TOTAL_W-1:0] rsp_free_bytes
);
   import ffa_pkg::*;

   bcast_type             bcast;
   scan_type              scan;
   link_type              links      [MAX_BLOCKS];
   link_type              prev_links [MAX_BLOCKS];
   link_type              next_links [MAX_BLOCKS];
   view_type              views      [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] hits;
   view_type              view_or;

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      if (k == 0) begin : g_first
         assign prev_links[k] = '0;
      end else begin : g_mid
         assign prev_links[k] = links[k-1];
      end
      if (k == MAX_BLOCKS - 1) begin : g_last
         assign next_links[k] = '0;
      end else begin : g_inner
         assign next_links[k] = links[k+1];
      end

      ffa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .head      ((k == 0) ? 1'b1 : 1'b0),
         .rst_blk   ((k == 0) ? BLOCK_ARENA : BLOCK_EMPTY),
         .bcast     (bcast),
         .prev_link (prev_links[k]),
         .next_link (next_links[k]),
         .link      (links[k]),
         .hit       (hits[k]),
         .view      (views[k])
      );
   end

   always_comb begin
      view_or = '0;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         view_or = view_or | views[k];
      end
   end

   assign scan.hit_any    = |hits;
   assign scan.tok_last   = links[MAX_BLOCKS-1].tok;
   assign scan.tail_valid = links[MAX_BLOCKS-1].blk.valid;
   assign scan.view       = view_or;

   ffa_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_size           (req_size),
      .req_data_offset    (req_data_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_granted_size   (rsp_granted_size),
      .rsp_free_bytes     (rsp_free_bytes),
      .scan               (scan),
      .bcast              (bcast)
   );

endmodule

`default_nettype wire

// ===== rtl/ffa_checker.sv =====
// Port-level checks for first_fit_block_allocator, attached by bind.
// Depends on ffa_pkg and the top level's ports.
`default_nettype none

module ffa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_status,
   input logic [ffa_pkg::OFS_W-1:0]   rsp_granted_offset,
   input logic [ffa_pkg::SIZE_W-1:0]  rsp_granted_size,
   input logic [ffa_pkg::TOTAL_W-1:0] rsp_free_bytes
);
   import ffa_pkg::*;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous request still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_granted_offset) && $stable(rsp_granted_size) &&
         $stable(rsp_free_bytes)))
      else $error("stalled response changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_granted_offset == '0 && rsp_granted_size == '0))
      else $error("error response carries grant data");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_bytes <= TOTAL_RESET))
      else $error("free byte count exceeds arena");

   a_ofs_past_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted_offset != '0) |-> (rsp_granted_offset >= HDR_OFS))
      else $error("granted offset inside a header");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (.*);

`default_nettype wire
